### sv/text_glyph_blitter_8x16_assert.svh
// ----------------------------------------------------------------------------
// text glyph blitter assertion macros
// Property macros shared by the blitter RTL, compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef TEXT_GLYPH_BLITTER_8X16_ASSERT_SVH
`define TEXT_GLYPH_BLITTER_8X16_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication under reset
`define TGB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define TGB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TGB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define TGB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### sv/tgb8x16_pkg.sv
// ----------------------------------------------------------------------------
// tgb8x16_pkg
// Beat types, operation and register codes and color helpers of the blitter.
// ----------------------------------------------------------------------------
package tgb8x16_pkg;

  // operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PLACE = 2'd1;
  localparam logic [1:0] OP_DRAW  = 2'd2;

  // configuration register indexes
  localparam logic [3:0] CFG_SCREEN_WIDTH = 4'd0;
  localparam logic [3:0] CFG_PIXEL_FORMAT = 4'd1;

  // pixel format codes
  localparam logic [1:0] FMT_8BPP  = 2'd0;
  localparam logic [1:0] FMT_16BPP = 2'd1;
  localparam logic [1:0] FMT_32BPP = 2'd2;

  localparam logic [7:0]  NEWLINE_CODE   = 8'h0A;
  localparam logic [11:0] WIDTH_RESET    = 12'd800;
  localparam logic [11:0] GLYPH_ADVANCE  = 12'd8;

  // input beat
  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] font_index;
    logic [7:0]  font_byte;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0]  char_code;
    logic [31:0] color;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic [23:0] row_address;
    logic [31:0] pixel_0;
    logic [31:0] pixel_1;
    logic [31:0] pixel_2;
    logic [31:0] pixel_3;
    logic [31:0] pixel_4;
    logic [31:0] pixel_5;
    logic [31:0] pixel_6;
    logic [31:0] pixel_7;
    logic        last_row;
  } out_beat_t;

  // request into the row address unit
  typedef struct packed {
    logic [11:0] row;
    logic [11:0] width;
    logic [11:0] col;
    logic [1:0]  shift;
  } row_req_t;

  // log2 of bytes per pixel
  function automatic logic [1:0] bpp_shift(input logic [1:0] fmt);
    logic [1:0] s;
    case (fmt)
      FMT_8BPP:  s = 2'd0;
      FMT_16BPP: s = 2'd1;
      default:   s = 2'd2;
    endcase
    return s;
  endfunction

  // foreground color in output format
  function automatic logic [31:0] convert_color(input logic [31:0] c,
                                                input logic [1:0]  fmt);
    logic [31:0] v;
    case (fmt)
      FMT_8BPP:  v = {24'd0, c[7:0]};
      FMT_16BPP: v = {16'd0, c[23:19], c[15:10], c[7:3]};
      default:   v = c;
    endcase
    return v;
  endfunction

endpackage

### sv/text_glyph_blitter_8x16.sv
// ----------------------------------------------------------------------------
// text_glyph_blitter_8x16
// 8x16 bitmap font character generator feeding a linear framebuffer.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i/in_ready_o, in_data_i): load a font byte, place
//     the cursor, or draw a character at the cursor.
//   out channel (out_valid_o/out_ready_i, out_data_o): one beat per glyph row,
//     row byte address plus eight pixel values, last_row on the final row.
//   cfg channel (cfg_valid_i/cfg_ready_o): screen width and pixel format,
//     always ready; write only while the block is idle.
// Timing:
//   load, place and newline give no beats and leave the block ready for the
//   next item. A draw issues one glyph row per cycle, unless a held output
//   beat stalls it, through the font store read port and the shared row
//   address multiplier; the next item is taken once the last row has left
//   the read stage. Each row beat is registered in the read stage, then at the output.
// Reset: cursor and line start go to 0, width to 800, format to 32 bpp.
//   The font store is not cleared and must be loaded before use.
// Stall: a held beat stops row issue once the read stage is full; no beat is lost or repeated.
// ----------------------------------------------------------------------------
`include "text_glyph_blitter_8x16_assert.svh"

module text_glyph_blitter_8x16 #(
  parameter int GLYPH_COUNT = 256,
  parameter int GLYPH_ROWS  = 16,
  parameter int MAX_WIDTH   = 2048
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  tgb8x16_pkg::in_beat_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output tgb8x16_pkg::out_beat_t out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [3:0]             cfg_index_i,
  input  logic [11:0]            cfg_data_i
);

  localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int ROW_W       = $clog2(GLYPH_ROWS);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e      state_q;
  logic [ROW_W-1:0] row_cnt_q;
  logic [IDX_W-1:0] base_q;
  logic [11:0] item_row_q;
  logic [11:0] item_col_q;
  logic [11:0] item_width_q;
  logic [1:0]  item_shift_q;
  logic [31:0] fg_q;
  logic [11:0] cursor_col_q;
  logic [11:0] cursor_row_q;
  logic [11:0] line_start_q;
  logic [11:0] screen_width_q;
  logic [1:0]  pixel_format_q;
  logic        s1_valid_q;
  logic        s1_last_q;
  logic        out_valid_q;
  tgb8x16_pkg::out_beat_t out_q;

  logic        in_fire;
  logic        is_draw;
  logic        is_newline;
  logic        issue;
  logic        s1_adv;
  logic        last_issue;
  logic [8:0]  code_ext;
  logic [IDX_W-1:0] glyph;
  logic [IDX_W-1:0] base_d;
  logic [11:0] width_eff;
  logic        load_we;
  logic [7:0]  rdata;
  logic [23:0] row_addr;
  tgb8x16_pkg::row_req_t req;
  tgb8x16_pkg::out_beat_t out_d;

  // input handshake and operation decode
  assign in_ready_o = (state_q == ST_IDLE) && !s1_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_draw    = in_data_i.operation == tgb8x16_pkg::OP_DRAW;
  assign is_newline = in_data_i.char_code == tgb8x16_pkg::NEWLINE_CODE;
  assign cfg_ready_o = 1'b1;

  // glyph number and its first row index
  assign code_ext = {1'b0, in_data_i.char_code};
  assign glyph    = (code_ext >= 9'(GLYPH_COUNT)) ? IDX_W'(code_ext - 9'(GLYPH_COUNT))
                                                  : IDX_W'(code_ext);
  assign base_d   = IDX_W'(glyph * IDX_W'(GLYPH_ROWS));

  // saturated screen width
  assign width_eff = ({1'b0, screen_width_q} > 13'(MAX_WIDTH)) ? 12'(MAX_WIDTH)
                                                               : screen_width_q;

  // font store load, out of range indexes ignored
  assign load_we = in_fire && (in_data_i.operation == tgb8x16_pkg::OP_LOAD) &&
                   ({1'b0, in_data_i.font_index} < 13'(STORE_DEPTH));

  // row issue and stage advance
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign issue      = (state_q == ST_RUN) && (!s1_valid_q || !out_valid_q || out_ready_i);
  assign last_issue = issue && (row_cnt_q == ROW_W'(GLYPH_ROWS - 1));

  tgb8x16_font_mem #(
    .DEPTH (STORE_DEPTH),
    .AW    (IDX_W)
  ) u_font_mem (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (in_data_i.font_index[IDX_W-1:0]),
    .wdata_i (in_data_i.font_byte),
    .re_i    (issue),
    .raddr_i (base_q + IDX_W'(row_cnt_q)),
    .rdata_o (rdata)
  );

  // row request for the shared address unit
  always_comb begin
    req.row   = item_row_q + 12'(row_cnt_q);
    req.width = item_width_q;
    req.col   = item_col_q;
    req.shift = item_shift_q;
  end

  tgb8x16_row_unit u_row_unit (
    .clk_i  (clk_i),
    .en_i   (issue),
    .req_i  (req),
    .addr_o (row_addr)
  );

  // expand glyph row bits, msb leftmost
  always_comb begin
    out_d.row_address = row_addr;
    out_d.pixel_0     = rdata[7] ? fg_q : 32'd0;
    out_d.pixel_1     = rdata[6] ? fg_q : 32'd0;
    out_d.pixel_2     = rdata[5] ? fg_q : 32'd0;
    out_d.pixel_3     = rdata[4] ? fg_q : 32'd0;
    out_d.pixel_4     = rdata[3] ? fg_q : 32'd0;
    out_d.pixel_5     = rdata[2] ? fg_q : 32'd0;
    out_d.pixel_6     = rdata[1] ? fg_q : 32'd0;
    out_d.pixel_7     = rdata[0] ? fg_q : 32'd0;
    out_d.last_row    = s1_last_q;
  end

  // sequencer, cursor, config and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      row_cnt_q      <= '0;
      base_q         <= '0;
      item_row_q     <= '0;
      item_col_q     <= '0;
      item_width_q   <= '0;
      item_shift_q   <= '0;
      fg_q           <= '0;
      cursor_col_q   <= '0;
      cursor_row_q   <= '0;
      line_start_q   <= '0;
      screen_width_q <= tgb8x16_pkg::WIDTH_RESET;
      pixel_format_q <= tgb8x16_pkg::FMT_32BPP;
      s1_valid_q     <= 1'b0;
      s1_last_q      <= 1'b0;
      out_valid_q    <= 1'b0;
      out_q          <= '0;
    end else begin
      // configuration writes
      if (cfg_valid_i) begin
        if (cfg_index_i == tgb8x16_pkg::CFG_SCREEN_WIDTH) begin
          screen_width_q <= cfg_data_i;
        end else if (cfg_index_i == tgb8x16_pkg::CFG_PIXEL_FORMAT) begin
          pixel_format_q <= cfg_data_i[1:0];
        end
      end

      // item accept
      if (in_fire) begin
        if (in_data_i.operation == tgb8x16_pkg::OP_PLACE) begin
          cursor_col_q <= in_data_i.pos_x;
          line_start_q <= in_data_i.pos_x;
          cursor_row_q <= in_data_i.pos_y;
        end else if (is_draw && is_newline) begin
          cursor_row_q <= cursor_row_q + 12'(GLYPH_ROWS);
          cursor_col_q <= line_start_q;
        end else if (is_draw) begin
          state_q      <= ST_RUN;
          row_cnt_q    <= '0;
          base_q       <= base_d;
          item_row_q   <= cursor_row_q;
          item_col_q   <= cursor_col_q;
          item_width_q <= width_eff;
          item_shift_q <= tgb8x16_pkg::bpp_shift(pixel_format_q);
          fg_q         <= tgb8x16_pkg::convert_color(in_data_i.color, pixel_format_q);
          cursor_col_q <= cursor_col_q + tgb8x16_pkg::GLYPH_ADVANCE;
        end
      end

      // row issue
      if (issue) begin
        row_cnt_q <= row_cnt_q + ROW_W'(1);
        s1_last_q <= last_issue;
        if (last_issue) begin
          state_q <= ST_IDLE;
        end
      end

      // read stage valid
      if (issue) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end

      // output register
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        out_q       <= out_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a draw that is not a newline starts the row sequencer
  `TGB_ASSERT_NXT(a_draw_starts, clk_i, rst_ni, in_fire && is_draw && !is_newline, state_q == ST_RUN, "draw did not start row issue")
  // the final row issue returns the sequencer to idle
  `TGB_ASSERT_NXT(a_last_ends, clk_i, rst_ni, last_issue, state_q == ST_IDLE && s1_last_q, "final row did not end the draw")
  // no row issue while the read stage is blocked by a held output beat
  `TGB_ASSERT_IMP(a_no_overrun, clk_i, rst_ni, s1_valid_q && out_valid_q && !out_ready_i, !issue, "row issued over a stalled stage")

endmodule

### sv/tgb8x16_font_mem.sv
// ----------------------------------------------------------------------------
// tgb8x16_font_mem
// Glyph row byte store, one write and one registered read port.
// ----------------------------------------------------------------------------
module tgb8x16_font_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/tgb8x16_row_unit.sv
// ----------------------------------------------------------------------------
// tgb8x16_row_unit
// Shared row address unit: row times width, plus column, scaled to bytes.
// ----------------------------------------------------------------------------
module tgb8x16_row_unit (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  tgb8x16_pkg::row_req_t  req_i,
  output logic [23:0]            addr_o
);

  logic [23:0] prod_q;
  logic [11:0] col_q;
  logic [1:0]  shift_q;
  logic [23:0] sum;

  // multiply stage, one row per enable
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= {12'd0, req_i.row} * {12'd0, req_i.width};
      col_q   <= req_i.col;
      shift_q <= req_i.shift;
    end
  end

  // add column and scale by bytes per pixel, wrapping at 24 bits
  assign sum    = prod_q + {12'd0, col_q};
  assign addr_o = sum << shift_q;

endmodule

### verif/tgb_row_checker.sv
// ----------------------------------------------------------------------------
// tgb_row_checker
// Watches the input, output and register write channels of the glyph blitter,
// keeps its own copy of the font store, cursor and settings, works out the
// glyph row beats every accepted draw should give and compares them in order.
// ----------------------------------------------------------------------------
module tgb_row_checker (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  tgb8x16_pkg::in_beat_t  in_data_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  tgb8x16_pkg::out_beat_t out_data_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [3:0]             cfg_index_i,
  input  logic [11:0]            cfg_data_i,
  output int                     mismatch_cnt_o,
  output int                     rows_pending_o
);

  localparam int          ROWS_PER_GLYPH = 16;
  localparam logic [11:0] WIDTH_LIMIT    = 12'd2048;
  localparam int          BEAT_FIELDS    = 10;

  localparam string FIELD_NAME [BEAT_FIELDS] = '{
    "row_address", "pixel_0", "pixel_1", "pixel_2", "pixel_3",
    "pixel_4", "pixel_5", "pixel_6", "pixel_7", "last_row"
  };

  // shadow of the block state
  logic [7:0]  glyph_mem [4096];
  logic [11:0] cur_col_q;
  logic [11:0] cur_row_q;
  logic [11:0] line_col_q;
  logic [11:0] width_q;
  logic [1:0]  fmt_q;

  // row beats still owed by the block, oldest first
  tgb8x16_pkg::out_beat_t rows_due [$];

  initial begin
    mismatch_cnt_o = 0;
    rows_pending_o = 0;
  end

  // foreground color in the current output format
  function automatic logic [31:0] fg_value(input logic [31:0] c);
    logic [31:0] r, g, b;
    r = (c >> 16) & 32'hFF;
    g = (c >> 8) & 32'hFF;
    b = c & 32'hFF;
    if (fmt_q == tgb8x16_pkg::FMT_8BPP) return b;
    if (fmt_q == tgb8x16_pkg::FMT_16BPP) return ((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3);
    return c;
  endfunction

  // one field of a row beat, widened for comparison
  function automatic logic [31:0] beat_field(input tgb8x16_pkg::out_beat_t b, input int k);
    case (k)
      0:       return 32'(b.row_address);
      1:       return b.pixel_0;
      2:       return b.pixel_1;
      3:       return b.pixel_2;
      4:       return b.pixel_3;
      5:       return b.pixel_4;
      6:       return b.pixel_5;
      7:       return b.pixel_6;
      8:       return b.pixel_7;
      default: return 32'(b.last_row);
    endcase
  endfunction

  // the sixteen row beats of one glyph at the cursor, then advance
  task automatic predict_glyph_rows(input tgb8x16_pkg::in_beat_t b);
    logic [31:0] fg, addr, bpp;
    logic [11:0] row, wid;
    logic [7:0]  bits;
    tgb8x16_pkg::out_beat_t r;
    wid = (width_q > WIDTH_LIMIT) ? WIDTH_LIMIT : width_q;
    bpp = (fmt_q == tgb8x16_pkg::FMT_8BPP)  ? 32'd1 :
          (fmt_q == tgb8x16_pkg::FMT_16BPP) ? 32'd2 : 32'd4;
    fg  = fg_value(b.color);
    for (int i = 0; i < ROWS_PER_GLYPH; i++) begin
      row  = cur_row_q + 12'(i);
      addr = (32'(row) * 32'(wid) + 32'(cur_col_q)) * bpp;
      bits = glyph_mem[{b.char_code, 4'(i)}];
      r.row_address = addr[23:0];
      r.pixel_0  = bits[7] ? fg : 32'd0;
      r.pixel_1  = bits[6] ? fg : 32'd0;
      r.pixel_2  = bits[5] ? fg : 32'd0;
      r.pixel_3  = bits[4] ? fg : 32'd0;
      r.pixel_4  = bits[3] ? fg : 32'd0;
      r.pixel_5  = bits[2] ? fg : 32'd0;
      r.pixel_6  = bits[1] ? fg : 32'd0;
      r.pixel_7  = bits[0] ? fg : 32'd0;
      r.last_row = (i == ROWS_PER_GLYPH - 1);
      rows_due.push_back(r);
    end
    cur_col_q = cur_col_q + tgb8x16_pkg::GLYPH_ADVANCE;
  endtask

  // compare one output beat with the oldest owed row
  task automatic check_row(input tgb8x16_pkg::out_beat_t got);
    tgb8x16_pkg::out_beat_t want;
    bit        bad;
    if (rows_due.size() == 0) begin
      if (mismatch_cnt_o < 10)
        $display("mismatch: row beat with none owed, address %h", got.row_address);
      mismatch_cnt_o++;
      return;
    end
    want = rows_due.pop_front();
    bad  = 1'b0;
    for (int k = 0; k < BEAT_FIELDS; k++) begin
      if (beat_field(got, k) !== beat_field(want, k)) begin
        if (mismatch_cnt_o < 10)
          $display("mismatch %s: expected %h, got %h", FIELD_NAME[k],
                   beat_field(want, k), beat_field(got, k));
        bad = 1'b1;
      end
    end
    if (bad) mismatch_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q  = '0;
      cur_row_q  = '0;
      line_col_q = '0;
      width_q    = tgb8x16_pkg::WIDTH_RESET;
      fmt_q      = tgb8x16_pkg::FMT_32BPP;
      rows_due.delete();
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          tgb8x16_pkg::CFG_SCREEN_WIDTH: width_q = cfg_data_i;
          tgb8x16_pkg::CFG_PIXEL_FORMAT: fmt_q = cfg_data_i[1:0];
          default: ;
        endcase
      end
      // output beats
      if (out_valid_i && out_ready_i) check_row(out_data_i);
      // input beats
      if (in_valid_i && in_ready_i) begin
        case (in_data_i.operation)
          tgb8x16_pkg::OP_LOAD: glyph_mem[in_data_i.font_index] = in_data_i.font_byte;
          tgb8x16_pkg::OP_PLACE: begin
            cur_col_q  = in_data_i.pos_x;
            line_col_q = in_data_i.pos_x;
            cur_row_q  = in_data_i.pos_y;
          end
          tgb8x16_pkg::OP_DRAW: begin
            if (in_data_i.char_code == tgb8x16_pkg::NEWLINE_CODE) begin
              cur_row_q = cur_row_q + 12'(ROWS_PER_GLYPH);
              cur_col_q = line_col_q;
            end else begin
              predict_glyph_rows(in_data_i);
            end
          end
          default: ;
        endcase
      end
    end
    rows_pending_o = rows_due.size();
  end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the glyph blitter through a short directed run at reset settings and
// then randomized phases of glyph loads, cursor moves, draws and newlines under
// several screen widths, pixel formats and idling patterns. A checker beside
// the block predicts and compares every row beat.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam logic [1:0] FMT_SPARE    = 2'd3;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         DRAIN_CYCLES = 24;
  localparam int         PHASE_ITEMS  = 52;
  localparam int         PHASES       = 8;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idling_e;

  localparam logic [7:0] EDGE_ROWS [16] = '{
    8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hF0, 8'h0F,
    8'hC3, 8'h3C, 8'h18, 8'h81, 8'h7E, 8'hE7, 8'h24, 8'hFF
  };
  localparam logic [11:0] PHASE_WIDTH [PHASES] = '{
    12'd2048, 12'd1, 12'd4095, 12'd0, 12'd640, 12'd2049, 12'd800, 12'd1023
  };
  localparam logic [1:0] PHASE_FMT [PHASES] = '{
    tgb8x16_pkg::FMT_8BPP, tgb8x16_pkg::FMT_16BPP, tgb8x16_pkg::FMT_32BPP, FMT_SPARE,
    tgb8x16_pkg::FMT_16BPP, tgb8x16_pkg::FMT_32BPP, tgb8x16_pkg::FMT_8BPP,
    tgb8x16_pkg::FMT_16BPP
  };
  localparam idling_e PHASE_IDLING [PHASES] = '{
    IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
    IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  tgb8x16_pkg::in_beat_t  in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  tgb8x16_pkg::out_beat_t out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i = '0;
  logic [11:0] cfg_data_i  = '0;

  int mismatches;
  int rows_pending;

  // idling percentages and the long receiver hold request
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_req = 1'b0;

  // font bytes loaded so far and glyphs fully loaded
  bit         byte_loaded [4096];
  bit         glyph_ready [256];
  logic [7:0] ready_codes [$];

  text_glyph_blitter_8x16 u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  tgb_row_checker u_row_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .in_data_i      (in_data_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_i     (out_data_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .mismatch_cnt_o (mismatches),
    .rows_pending_o (rows_pending)
  );

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #8000000;
    $display("status: fail");
    $finish;
  end

  // receiver: random stalls plus one long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // beat with every field random, specific fields overwritten by the caller
  function automatic tgb8x16_pkg::in_beat_t noise_beat();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return tgb8x16_pkg::in_beat_t'(raw[$bits(tgb8x16_pkg::in_beat_t)-1:0]);
  endfunction

  function automatic logic [11:0] pick_coord();
    case ($urandom_range(3))
      0:       return 12'hFFF - 12'($urandom_range(15));
      1:       return 12'($urandom_range(15));
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_color();
    case ($urandom_range(9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // offer one input beat, with random idle cycles ahead of it
  task automatic push_item(input tgb8x16_pkg::in_beat_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic load_byte(input logic [11:0] idx, input logic [7:0] val);
    tgb8x16_pkg::in_beat_t b;
    logic [7:0] code;
    bit         full;
    b = noise_beat();
    b.operation  = tgb8x16_pkg::OP_LOAD;
    b.font_index = idx;
    b.font_byte  = val;
    push_item(b);
    byte_loaded[idx] = 1'b1;
    code = idx[11:4];
    full = 1'b1;
    for (int r = 0; r < 16; r++) full &= byte_loaded[{code, 4'(r)}];
    // newline code never reads its glyph, so it never joins the drawable set
    if (full && !glyph_ready[code] && code != tgb8x16_pkg::NEWLINE_CODE) begin
      glyph_ready[code] = 1'b1;
      ready_codes.push_back(code);
    end
  endtask

  task automatic place_cursor(input logic [11:0] x, input logic [11:0] y);
    tgb8x16_pkg::in_beat_t b;
    b = noise_beat();
    b.operation = tgb8x16_pkg::OP_PLACE;
    b.pos_x     = x;
    b.pos_y     = y;
    push_item(b);
  endtask

  task automatic draw_char(input logic [7:0] code, input logic [31:0] color);
    tgb8x16_pkg::in_beat_t b;
    b = noise_beat();
    b.operation = tgb8x16_pkg::OP_DRAW;
    b.char_code = code;
    b.color     = color;
    push_item(b);
  endtask

  task automatic unused_op();
    tgb8x16_pkg::in_beat_t b;
    b = noise_beat();
    b.operation = OP_UNUSED;
    push_item(b);
  endtask

  // both register beats back to back, valid held across them
  task automatic write_regs(input logic [11:0] width, input logic [1:0] fmt);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= tgb8x16_pkg::CFG_SCREEN_WIDTH;
    cfg_data_i  <= width;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= tgb8x16_pkg::CFG_PIXEL_FORMAT;
    cfg_data_i  <= {10'd0, fmt};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // stop offering and let every owed row come out, then let the block settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do begin
      while (rows_pending != 0) @(posedge clk_i);
      repeat (DRAIN_CYCLES) @(posedge clk_i);
    end while (rows_pending != 0);
  endtask

  task automatic set_idling(input idling_e mode);
    case (mode)
      IDLE_SEND: begin tx_idle_pct = 59; rx_stall_pct = 0;  end
      IDLE_RECV: begin tx_idle_pct = 0;  rx_stall_pct = 59; end
      IDLE_BOTH: begin tx_idle_pct = 10; rx_stall_pct = 10; end
      default:   begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
    endcase
  endtask

  // mostly draws of loaded glyphs, with glyph loads, moves, newlines and noise mixed in
  task automatic random_phase(input int quota);
    int         done, pick;
    logic [7:0] code;
    done = 0;
    while (done < quota) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        code = 8'($urandom);
        for (int r = 0; r < 16; r++) load_byte({code, 4'(r)}, 8'($urandom));
        done += 16;
      end else if (pick < 20) begin
        place_cursor(pick_coord(), pick_coord());
        done++;
      end else if (pick < 28) begin
        draw_char(tgb8x16_pkg::NEWLINE_CODE, pick_color());
        done++;
      end else if (pick < 32) begin
        unused_op();
        done++;
      end else if (pick < 40) begin
        load_byte(12'($urandom), 8'($urandom));
        done++;
      end else begin
        code = ready_codes[$urandom_range(ready_codes.size() - 1)];
        draw_char(code, pick_color());
        done++;
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: one glyph of edge patterns, wrap at the far corner, newline
    for (int r = 0; r < 16; r++) load_byte({8'hFF, 4'(r)}, EDGE_ROWS[r]);
    place_cursor(12'd4092, 12'd4090);
    draw_char(8'hFF, 32'hFFFF_FFFF);
    draw_char(8'hFF, 32'h0);
    draw_char(tgb8x16_pkg::NEWLINE_CODE, 32'h0);
    unused_op();
    place_cursor(12'd0, 12'd0);
    draw_char(8'hFF, 32'h1234_5678);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_regs((p >= PHASES - 2) ? 12'($urandom) : PHASE_WIDTH[p], PHASE_FMT[p]);
      set_idling(PHASE_IDLING[p]);
      // long receiver hold while the sender keeps offering
      if (p == 0) hold_req = 1'b1;
      random_phase(PHASE_ITEMS);
    end
    wait_drained();

    if (mismatches == 0 && rows_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
